// ----- rtl/svcf_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svcf_pkg: servo command frame builder package
// Shared codes, frame constants and inter-module types.
// ---------------------------------------------------------------------------
package svcf_pkg;

    // Request kinds
    localparam logic [2:0] CMD_PING       = 3'd0;
    localparam logic [2:0] CMD_ANGLE_MOVE = 3'd1;
    localparam logic [2:0] CMD_ANGLE_READ = 3'd2;
    localparam logic [2:0] CMD_DATA_READ  = 3'd3;
    localparam logic [2:0] CMD_DATA_MON   = 3'd4;

    // Frame opcodes
    localparam logic [7:0] OP_PING       = 8'h01;
    localparam logic [7:0] OP_ANGLE_MOVE = 8'h08;
    localparam logic [7:0] OP_ANGLE_READ = 8'h0A;
    localparam logic [7:0] OP_DATA_READ  = 8'h03;
    localparam logic [7:0] OP_DATA_MON   = 8'h16;

    // Content length bytes
    localparam logic [7:0] CLEN_SHORT = 8'h01;
    localparam logic [7:0] CLEN_TYPE  = 8'h02;
    localparam logic [7:0] CLEN_MOVE  = 8'h07;

    // Frame geometry: bytes ahead of the checksum
    localparam int unsigned FRAME_BODY_BYTES = 11;
    localparam int unsigned COUNT_W          = 4;
    localparam logic [COUNT_W-1:0] BODY_LEN_SHORT = 4'd5;
    localparam logic [COUNT_W-1:0] BODY_LEN_TYPE  = 4'd6;
    localparam logic [COUNT_W-1:0] BODY_LEN_MOVE  = 4'd11;

    // Configuration registers
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;
    localparam logic [7:0] HEADER_FIRST_RST  = 8'h12;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h4C;

    typedef logic [FRAME_BODY_BYTES-1:0][7:0] frame_body_t;

    // Shifter status toward the control in the top level
    typedef struct packed {
        logic       busy;   // bytes of a frame still to go
        logic       last;   // only the checksum slot remains
        logic [7:0] head;   // byte at the shifter output
    } shift_stat_t;

    // Checksum accumulator control
    typedef struct packed {
        logic       clear;
        logic       add;
        logic [7:0] data;
    } sum_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/svcf_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svcf_if: servo request and frame byte channels
// Valid/ready channels carrying one request and one frame byte.
// ---------------------------------------------------------------------------
interface svcf_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  command;
    logic        [7:0]  target_id;
    logic signed [15:0] target_angle;
    logic        [15:0] move_time;
    logic        [7:0]  type_code;

    modport source (output valid, command, target_id, target_angle, move_time, type_code,
                    input ready);
    modport sink   (input valid, command, target_id, target_angle, move_time, type_code,
                    output ready);
endinterface

interface svcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, tx_byte, frame_end, input ready);
    modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/svcf_shift.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svcf_shift: frame byte shifter
// Holds the frame body and shifts it out one byte per advance.
// ---------------------------------------------------------------------------
module svcf_shift
    import svcf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire frame_body_t        body,
    input  wire logic [COUNT_W-1:0] body_len,
    input  wire logic               advance,
    output shift_stat_t             stat
);

    frame_body_t        data_reg, data_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        data_next  = data_reg;
        count_next = count_reg;
        priority if (load)
        begin
            data_next  = body;
            count_next = body_len + 1'b1;   // body plus checksum
        end
        else if (advance && count_reg != '0)
        begin
            // drop the head byte, move the rest down
            for (int i = 0; i < FRAME_BODY_BYTES - 1; i++)
            begin
                data_next[i] = data_reg[i+1];
            end
            data_next[FRAME_BODY_BYTES-1] = 8'h00;
            count_next = count_reg - 1'b1;
        end
        else
        begin
            // hold
            data_next  = data_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stat.busy = (count_reg != '0);
    assign stat.last = (count_reg == COUNT_W'(1));
    assign stat.head = data_reg[0];

endmodule
`default_nettype wire

// ----- rtl/svcf_sum.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svcf_sum: frame checksum accumulator
// Adds each frame body byte as it leaves, modulo 256.
// ---------------------------------------------------------------------------
module svcf_sum
    import svcf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sum_ctrl_t ctrl,
    output logic [7:0]     sum
);

    logic [7:0] sum_reg, sum_next;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            sum_next = 8'h00;
        end
        else if (ctrl.add)
        begin
            sum_next = sum_reg + ctrl.data;
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'h00;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

// ----- rtl/servo_command_frame_builder.sv -----
`default_nettype none
// The first frame byte passes the shifter register, then the output register.
// Throughput: one frame byte per cycle from the byte shifter while the sink
// is ready; a frame of N bytes (6, 7 or 12) holds the request channel until
// the shifter hands over its checksum. Unknown kinds are accepted and dropped.
// Reset: header registers return to 0x12 / 0x4C, shifter and output go empty.
// ---------------------------------------------------------------------------
// servo_command_frame_builder: servo request frame builder
// Turns one servo request into its byte frame, closed by an 8-bit sum.
// ---------------------------------------------------------------------------
module servo_command_frame_builder
    import svcf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    svcf_req_if.sink                   req,
    svcf_byte_if.source                frame,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    // -----------------------------------------------------------------------
    // Header registers: the user must write them only while the block is idle; the block itself does not enforce it
    // -----------------------------------------------------------------------
    logic [7:0] header_first_reg, header_first_next;
    logic [7:0] header_second_reg, header_second_next;

    always_comb
    begin
        header_first_next  = header_first_reg;
        header_second_next = header_second_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_HEADER_FIRST:  header_first_next  = wr_data;
                REG_HEADER_SECOND: header_second_next = wr_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
        end
        else
        begin
            header_first_reg  <= header_first_next;
            header_second_reg <= header_second_next;
        end
    end

    // -----------------------------------------------------------------------
    // Request intake: assemble the frame body for the shifter
    // -----------------------------------------------------------------------
    shift_stat_t        stat;
    frame_body_t        body;
    logic [COUNT_W-1:0] body_len;
    logic               cmd_known;
    logic               accept;
    logic               load;

    always_comb
    begin
        body      = '0;
        body_len  = BODY_LEN_SHORT;
        cmd_known = 1'b1;
        body[0]   = header_first_reg;
        body[1]   = header_second_reg;
        body[4]   = req.target_id;
        unique case (req.command)
            CMD_PING:
            begin
                body[2] = OP_PING;
                body[3] = CLEN_SHORT;
            end
            CMD_ANGLE_MOVE:
            begin
                // angle and time go little-endian, then two zero power bytes
                body[2]  = OP_ANGLE_MOVE;
                body[3]  = CLEN_MOVE;
                body[5]  = req.target_angle[7:0];
                body[6]  = req.target_angle[15:8];
                body[7]  = req.move_time[7:0];
                body[8]  = req.move_time[15:8];
                body_len = BODY_LEN_MOVE;
            end
            CMD_ANGLE_READ:
            begin
                body[2] = OP_ANGLE_READ;
                body[3] = CLEN_SHORT;
            end
            CMD_DATA_READ:
            begin
                body[2]  = OP_DATA_READ;
                body[3]  = CLEN_TYPE;
                body[5]  = req.type_code;
                body_len = BODY_LEN_TYPE;
            end
            CMD_DATA_MON:
            begin
                body[2]  = OP_DATA_MON;
                body[3]  = CLEN_TYPE;
                body[5]  = req.type_code;
                body_len = BODY_LEN_TYPE;
            end
            default:
            begin
                // unknown request kind: drop it, emit nothing
                cmd_known = 1'b0;
            end
        endcase
    end

    // Take a new request once the shifter has handed over its last byte;
    // the output register may still hold that byte.
    assign req.ready = !stat.busy;
    assign accept    = req.valid && req.ready;
    assign load      = accept && cmd_known;

    // -----------------------------------------------------------------------
    // Byte shifter and checksum
    // -----------------------------------------------------------------------
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_end_reg, out_end_next;
    logic               advance;
    logic [7:0]         sum;
    sum_ctrl_t          sum_ctrl;

    // Advance when a byte is pending and the output register is free or draining.
    assign advance = stat.busy && (!out_valid_reg || frame.ready);

    svcf_shift u_shift (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .body     (body),
        .body_len (body_len),
        .advance  (advance),
        .stat     (stat)
    );

    // Clear on load, add every body byte as it leaves the shifter.
    assign sum_ctrl.clear = load;
    assign sum_ctrl.add   = advance && !stat.last;
    assign sum_ctrl.data  = stat.head;

    svcf_sum u_sum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sum_ctrl),
        .sum   (sum)
    );

    // -----------------------------------------------------------------------
    // Output register: the checksum slot takes the accumulated sum
    // -----------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        priority if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = stat.last ? sum : stat.head;
            out_end_next   = stat.last;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            // hold the byte until the sink takes it
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    assign frame.valid     = out_valid_reg;
    assign frame.tx_byte   = out_byte_reg;
    assign frame.frame_end = out_end_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> stat.busy)
        else $error("shifter not busy after frame load");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stat.last |=> !stat.busy)
        else $error("shifter still busy after checksum slot");

    a_busy_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat.busy) |-> $past(load))
        else $error("shifter started without a load");

    a_end_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> frame.valid && (frame.frame_end == $past(stat.last)))
        else $error("frame end mark does not follow checksum slot");

endmodule
`default_nettype wire

// ----- sim/servo_command_frame_builder_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_command_frame_builder_test: request frame builder testbench
// Offers servo requests on the request channel and checks every frame byte
// and end mark against a frame predictor kept in this module. A directed
// table covers each request kind, field extremes and unknown kinds. Random
// phases follow under new header settings and varied idling. One phase
// holds the byte sink off long enough to back up the request channel.
// ---------------------------------------------------------------------------
module servo_command_frame_builder_test;
    import svcf_pkg::*;

    // Request kinds the block has no frame for: accepted and dropped
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int unsigned SETTLE_CYCLES  = 6;     // request to first byte passes the shifter and output registers
    localparam int unsigned HOLD_CYCLES    = 400;   // long sink hold-off
    localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int unsigned PHASE_ITEMS    = 80;
    localparam int unsigned NUM_DIRECTED   = 18;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        logic        [2:0]  command;
        logic        [7:0]  target_id;
        logic signed [15:0] target_angle;
        logic        [15:0] move_time;
        logic        [7:0]  type_code;
    } servo_request_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    // One row of the directed table; sum_known marks a checksum typed in here
    typedef struct packed {
        servo_request_t request;
        logic           sum_known;
        logic [7:0]     sum_typed;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    svcf_req_if  request_bus ();
    svcf_byte_if frame_bus ();

    servo_command_frame_builder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (request_bus),
        .frame    (frame_bus),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predictor copy of the header registers
    logic [7:0] header_first_copy;
    logic [7:0] header_second_copy;

    // Frame bytes still owed by the block, oldest first
    frame_byte_t owed_bytes [$];

    int unsigned error_count;
    int unsigned send_gap_pct;     // chance in a hundred of a sender gap cycle
    int unsigned ready_stall_pct;  // chance in a hundred of ready low
    int unsigned hold_requests;    // bump to ask the sink for a long hold-off

    directed_row_t directed_rows [NUM_DIRECTED];

    initial
    begin : clock_gen
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Build the frame a request must produce and append it to the owed bytes.
    // A typed-in checksum replaces the computed one so that it is checked
    // against the block directly.
    function automatic void queue_frame_bytes(input servo_request_t r,
                                              input logic sum_known,
                                              input logic [7:0] sum_typed);
        logic [7:0] body [$];
        logic [7:0] sum;
        body.push_back(header_first_copy);
        body.push_back(header_second_copy);
        case (r.command)
            CMD_PING:
            begin
                body.push_back(OP_PING);
                body.push_back(CLEN_SHORT);
                body.push_back(r.target_id);
            end
            CMD_ANGLE_MOVE:
            begin
                body.push_back(OP_ANGLE_MOVE);
                body.push_back(CLEN_MOVE);
                body.push_back(r.target_id);
                body.push_back(r.target_angle[7:0]);
                body.push_back(r.target_angle[15:8]);
                body.push_back(r.move_time[7:0]);
                body.push_back(r.move_time[15:8]);
                body.push_back(8'h00);
                body.push_back(8'h00);
            end
            CMD_ANGLE_READ:
            begin
                body.push_back(OP_ANGLE_READ);
                body.push_back(CLEN_SHORT);
                body.push_back(r.target_id);
            end
            CMD_DATA_READ:
            begin
                body.push_back(OP_DATA_READ);
                body.push_back(CLEN_TYPE);
                body.push_back(r.target_id);
                body.push_back(r.type_code);
            end
            CMD_DATA_MON:
            begin
                body.push_back(OP_DATA_MON);
                body.push_back(CLEN_TYPE);
                body.push_back(r.target_id);
                body.push_back(r.type_code);
            end
            default:
                return;
        endcase
        sum = 8'h00;
        foreach (body[i])
        begin
            sum = sum + body[i];
            owed_bytes.push_back('{value: body[i], last: 1'b0});
        end
        if (sum_known)
            sum = sum_typed;
        owed_bytes.push_back('{value: sum, last: 1'b1});
    endfunction

    function automatic servo_request_t random_request();
        servo_request_t r;
        // Mostly real request kinds; now and then one the block must drop
        if ($urandom_range(9) == 0)
            r.command = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
        else
            r.command = 3'($urandom_range(CMD_DATA_MON, CMD_PING));
        r.target_id    = 8'($urandom);
        r.target_angle = 16'($urandom);
        r.move_time    = 16'($urandom);
        r.type_code    = 8'($urandom);
        return r;
    endfunction

    // Offer one request and hold it until the block takes it. Call at a
    // rising-edge time step; returns at the edge that accepted the request.
    task automatic offer_request(input servo_request_t r, input logic sum_known,
                                 input logic [7:0] sum_typed);
        while ($urandom_range(99) < send_gap_pct)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid        <= 1'b1;
        request_bus.command      <= r.command;
        request_bus.target_id    <= r.target_id;
        request_bus.target_angle <= r.target_angle;
        request_bus.move_time    <= r.move_time;
        request_bus.type_code    <= r.type_code;
        do
            @(posedge clk);
        while (request_bus.ready !== 1'b1);
        queue_frame_bytes(r, sum_known, sum_typed);
    endtask

    // Drop valid, wait for every owed byte, then let a dropped request or
    // the shifter's tail drain before anything touches the registers.
    task automatic drain();
        request_bus.valid <= 1'b0;
        while (owed_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both header registers; only ever called with the block idle
    task automatic program_headers(input logic [7:0] first, input logic [7:0] second);
        wr_en    <= 1'b1;
        wr_index <= REG_HEADER_FIRST;
        wr_data  <= first;
        @(posedge clk);
        header_first_copy = first;
        wr_index <= REG_HEADER_SECOND;
        wr_data  <= second;
        @(posedge clk);
        header_second_copy = second;
        wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned gap_pct,
                              input int unsigned stall_pct);
        send_gap_pct    = gap_pct;
        ready_stall_pct = stall_pct;
        repeat (count) offer_request(random_request(), 1'b0, 8'h00);
        drain();
    endtask

    // Byte sink: random stalls, plus a long hold-off whenever one is asked
    initial
    begin : byte_sink
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left       = 0;
        holds_served    = 0;
        frame_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_bus.ready <= 1'b0;
            end
            else
                frame_bus.ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Check every accepted byte against the oldest owed one
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1)
        begin
            if (owed_bytes.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected byte %h end %b", frame_bus.tx_byte,
                             frame_bus.frame_end);
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (frame_bus.tx_byte !== want.value || frame_bus.frame_end !== want.last)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("byte mismatch: expected %h end %b, got %h end %b",
                                 want.value, want.last, frame_bus.tx_byte,
                                 frame_bus.frame_end);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((request_bus.valid === 1'b1 && request_bus.ready === 1'b1)
                || (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        // Directed table. Typed checksums assume the reset headers 0x12 0x4C,
        // whose sum is 0x5E.
        directed_rows = '{
            // ping at both id extremes
            '{'{CMD_PING,       8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h60},
            '{'{CMD_PING,       8'hFF, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h5F},
            // angle read at both id extremes
            '{'{CMD_ANGLE_READ, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h69},
            '{'{CMD_ANGLE_READ, 8'hFF, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h68},
            // angle move: largest angle and time, most negative angle, all zero
            '{'{CMD_ANGLE_MOVE, 8'hFF, 16'h7FFF, 16'hFFFF, 8'h00}, 1'b1, 8'hE8},
            '{'{CMD_ANGLE_MOVE, 8'h00, 16'h8000, 16'h0000, 8'h00}, 1'b1, 8'hED},
            '{'{CMD_ANGLE_MOVE, 8'h01, 16'hFFFF, 16'h1234, 8'h00}, 1'b1, 8'hB2},
            '{'{CMD_ANGLE_MOVE, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h6D},
            // data read and data monitor at type extremes
            '{'{CMD_DATA_READ,  8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h63},
            '{'{CMD_DATA_READ,  8'h00, 16'h0000, 16'h0000, 8'hFF}, 1'b1, 8'h62},
            '{'{CMD_DATA_MON,   8'hFF, 16'h0000, 16'h0000, 8'hFF}, 1'b1, 8'h74},
            '{'{CMD_DATA_MON,   8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, 8'h76},
            // unknown kinds: accepted, no frame
            '{'{CMD_RSVD5,      8'h12, 16'h7FFF, 16'hFFFF, 8'hFF}, 1'b0, 8'h00},
            '{'{CMD_RSVD6,      8'hFF, 16'h8000, 16'h0000, 8'h00}, 1'b0, 8'h00},
            '{'{CMD_RSVD7,      8'hA5, 16'hFFFF, 16'h5A5A, 8'h3C}, 1'b0, 8'h00},
            // fields a kind does not use must not leak into its frame
            '{'{CMD_PING,       8'h5A, 16'h1234, 16'hABCD, 8'h77}, 1'b1, 8'hBA},
            '{'{CMD_DATA_READ,  8'h33, 16'h8000, 16'hFFFF, 8'h80}, 1'b0, 8'h00},
            '{'{CMD_ANGLE_MOVE, 8'h80, 16'h0100, 16'h00FF, 8'hFF}, 1'b0, 8'h00}
        };

        // Every block input known from time zero
        error_count     = 0;
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        hold_requests   = 0;
        rst_n           = 1'b0;
        wr_en           = 1'b0;
        wr_index        = REG_HEADER_FIRST;
        wr_data         = '0;
        request_bus.valid        = 1'b0;
        request_bus.command      = CMD_PING;
        request_bus.target_id    = '0;
        request_bus.target_angle = '0;
        request_bus.move_time    = '0;
        request_bus.type_code    = '0;
        header_first_copy  = HEADER_FIRST_RST;
        header_second_copy = HEADER_SECOND_RST;

        // Hold reset, then release it on an edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset headers, no idling on either side
        foreach (directed_rows[i])
            offer_request(directed_rows[i].request, directed_rows[i].sum_known,
                          directed_rows[i].sum_typed);
        drain();

        // Header extremes, then random headers, under the idling mixes
        program_headers(8'h00, 8'h00);
        run_random(PHASE_ITEMS, 0, 0);

        program_headers(8'hFF, 8'hFF);
        run_random(PHASE_ITEMS, 77, 0);

        program_headers(8'($urandom), 8'($urandom));
        run_random(PHASE_ITEMS, 0, 77);

        program_headers(8'($urandom), 8'($urandom));
        run_random(PHASE_ITEMS, 25, 25);

        // Back pressure: hold the sink off while requests keep coming, so
        // the shifter fills and the request channel stalls
        program_headers(HEADER_FIRST_RST, HEADER_SECOND_RST);
        hold_requests++;
        run_random(PHASE_ITEMS, 0, 0);

        // Owed bytes are drained by run_random; anything left is a miss
        if (error_count == 0 && owed_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
